@@ design/okvt_pkg.sv @@
package okvt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W     = 64;

    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_LOOKUP  = 3'd1;
    localparam logic [2:0] CMD_REMOVE  = 3'd2;
    localparam logic [2:0] CMD_CUR_RST = 3'd3;
    localparam logic [2:0] CMD_CUR_ADV = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] key;
        logic [31:0]        value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        value_out;
        logic [CNT_W-1:0]   entry_count;
        logic               cursor_at_end;
        logic signed [31:0] cursor_key;
        logic [31:0]        cursor_value;
    } t_out_word;

endpackage

@@ design/okvt_ram.sv @@
module okvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ordered_key_value_table.sv @@
// Ordered key/value table: up to TABLE_DEPTH entries kept in insertion order in a
// single-port-read entry RAM. One word in, one word out; the input is stalled while
// a word is in progress. Insert, lookup and remove scan the stored entries one per
// cycle, and a hit ends the scan early. On a hit, remove then shifts each later entry
// down by one slot. Cursor reset, cursor advance and the unused commands skip the scan.
// A stalled output holds the block in its last state until the output register frees
// up, and the input reopens in the same cycle as the result is registered. The result
// sits in an output register, so the next word is taken while the previous result is
// still waiting.
module ordered_key_value_table
    import okvt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_SHIFT    = 3'd2;
    localparam logic [2:0] S_CUR_RD   = 3'd3;
    localparam logic [2:0] S_CUR_WAIT = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_cmd, n_cmd;
    logic [31:0]       r_key, n_key;
    logic [31:0]       r_val, n_val;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic              r_cur_valid, n_cur_valid;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [ADDR_W-1:0] r_pidx, n_pidx;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_slot, n_slot;
    logic [1:0]        r_status, n_status;
    logic [31:0]       r_vout, n_vout;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic              in_acc;
    logic              out_free;
    logic              hit;
    logic [CNT_W-1:0]  idx_nxt;
    logic [CNT_W-1:0]  cnt_dec;
    logic [ADDR_W-1:0] pos_adj;

    okvt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_entries (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign hit      = r_pend && (ram_rdata[63:32] == r_key);
    assign idx_nxt  = r_idx + 1'b1;
    assign cnt_dec  = r_count - 1'b1;
    assign pos_adj  = (r_pos > r_slot) ? (r_pos - 1'b1) : r_pos;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_val       = r_val;
        n_count     = r_count;
        n_pos       = r_pos;
        n_cur_valid = r_cur_valid;
        n_idx       = r_idx;
        n_pidx      = r_pidx;
        n_pend      = 1'b0;
        n_slot      = r_slot;
        n_status    = r_status;
        n_vout      = r_vout;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        ram_we      = 1'b0;
        ram_waddr   = r_pidx;
        ram_wdata   = {r_key, r_val};
        ram_raddr   = r_idx[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd    = i_in_word.cmd;
                    n_key    = i_in_word.key;
                    n_val    = i_in_word.value;
                    n_status = ST_OK;
                    n_vout   = '0;
                    n_idx    = '0;
                    unique case (i_in_word.cmd)
                        CMD_INSERT, CMD_LOOKUP, CMD_REMOVE: begin
                            n_state = S_SCAN;
                        end
                        CMD_CUR_RST: begin
                            n_pos       = '0;
                            n_cur_valid = (r_count != '0);
                            n_state     = S_CUR_RD;
                        end
                        CMD_CUR_ADV: begin
                            if (r_cur_valid) begin
                                if (CNT_W'(r_pos) + 1'b1 < r_count) begin
                                    n_pos = r_pos + 1'b1;
                                end else begin
                                    n_pos       = '0;
                                    n_cur_valid = 1'b0;
                                end
                            end
                            n_state = S_CUR_RD;
                        end
                        default: begin
                            n_state = S_CUR_RD;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (hit) begin
                    n_slot = r_pidx;
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pidx;
                            n_state   = S_CUR_RD;
                        end
                        CMD_LOOKUP: begin
                            n_vout  = ram_rdata[31:0];
                            n_state = S_CUR_RD;
                        end
                        default: begin
                            n_idx   = CNT_W'(r_pidx);
                            n_state = S_SHIFT;
                        end
                    endcase
                end else if (!r_pend && (r_idx == r_count)) begin
                    n_state = S_CUR_RD;
                    if (r_cmd == CMD_INSERT) begin
                        if (r_count < CNT_W'(TABLE_DEPTH)) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[ADDR_W-1:0];
                            n_count   = r_count + 1'b1;
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end else if (r_idx < r_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[ADDR_W-1:0];
                    n_idx  = idx_nxt;
                end
            end

            S_SHIFT: begin
                // read entry i+1 while writing the previous one down
                ram_raddr = idx_nxt[ADDR_W-1:0];
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pidx;
                    ram_wdata = ram_rdata;
                end
                if (idx_nxt < r_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[ADDR_W-1:0];
                    n_idx  = idx_nxt;
                end else if (!r_pend) begin
                    n_count = cnt_dec;
                    if (r_cur_valid) begin
                        if (CNT_W'(pos_adj) >= cnt_dec) begin
                            n_cur_valid = 1'b0;
                            n_pos       = '0;
                        end else begin
                            n_pos = pos_adj;
                        end
                    end
                    n_state = S_CUR_RD;
                end
            end

            S_CUR_RD: begin
                ram_raddr = r_pos;
                n_state   = S_CUR_WAIT;
            end

            S_CUR_WAIT: begin
                ram_raddr = r_pos;
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_word.status        = r_status;
                    n_out_word.value_out     = r_vout;
                    n_out_word.entry_count   = r_count;
                    n_out_word.cursor_at_end = !r_cur_valid;
                    n_out_word.cursor_key    = r_cur_valid ? ram_rdata[63:32] : '0;
                    n_out_word.cursor_value  = r_cur_valid ? ram_rdata[31:0] : '0;
                    n_state                  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_cur_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_cur_valid <= n_cur_valid;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_slot     <= n_slot;
        r_status   <= n_status;
        r_vout     <= n_vout;
        r_out_word <= n_out_word;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (CNT_W'(r_pos) < r_count))
        else $error("cursor beyond stored entries");

    a_cursor_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cur_valid |-> (r_pos == '0))
        else $error("cursor at end but position not zero");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    a_end_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.cursor_at_end) |->
        (o_out_word.cursor_key == '0 && o_out_word.cursor_value == '0))
        else $error("cursor fields not zero at end");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import okvt_pkg::*;

    localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;
    localparam logic [31:0] KEY_MIN       = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] KEY_NEG1      = 32'hFFFF_FFFF;
    localparam int          RANDOM_WORDS  = 1750;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          DRAIN_CYCLES  = 200;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word want;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    logic [31:0] tbl_keys [TABLE_DEPTH];
    logic [31:0] tbl_vals [TABLE_DEPTH];
    int          tbl_count;
    int          cur_pos;
    bit          cur_live;

    t_out_word   pending_results[$];
    t_stim_row   dir_rows[$];
    int          words_taken;
    int          results_checked;
    int          mismatch_count;
    bit          calm_window;
    bit          hold_request;

    ordered_key_value_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("ordered_key_value_table verification failed");
        $finish;
    end

    function automatic int find_key(logic [31:0] k);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_keys[i] == k) return i;
        end
        return tbl_count;
    endfunction

    function automatic t_out_word table_apply(t_in_word w);
        t_out_word r;
        int        slot;
        r = '0;
        r.status = ST_OK;
        slot = find_key(w.key);
        case (w.cmd)
            CMD_INSERT: begin
                if (slot < tbl_count) begin
                    tbl_vals[slot] = w.value;
                end else if (tbl_count < TABLE_DEPTH) begin
                    tbl_keys[tbl_count] = w.key;
                    tbl_vals[tbl_count] = w.value;
                    tbl_count++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            CMD_LOOKUP: begin
                if (slot < tbl_count) r.value_out = tbl_vals[slot];
                else r.status = ST_NOT_FOUND;
            end
            CMD_REMOVE: begin
                if (slot < tbl_count) begin
                    for (int i = slot; i + 1 < tbl_count; i++) begin
                        tbl_keys[i] = tbl_keys[i + 1];
                        tbl_vals[i] = tbl_vals[i + 1];
                    end
                    tbl_count--;
                    if (cur_live) begin
                        if (cur_pos > slot) cur_pos--;
                        if (cur_pos >= tbl_count) begin
                            cur_live = 1'b0;
                            cur_pos  = 0;
                        end
                    end
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            CMD_CUR_RST: begin
                cur_pos  = 0;
                cur_live = (tbl_count != 0);
            end
            CMD_CUR_ADV: begin
                if (cur_live) begin
                    if (cur_pos + 1 < tbl_count) begin
                        cur_pos++;
                    end else begin
                        cur_live = 1'b0;
                        cur_pos  = 0;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = CNT_W'(tbl_count);
        if (cur_live) begin
            r.cursor_key   = tbl_keys[cur_pos];
            r.cursor_value = tbl_vals[cur_pos];
        end else begin
            r.cursor_at_end = 1'b1;
        end
        return r;
    endfunction

    function automatic t_in_word mk_word(logic [2:0] cmd, logic [31:0] k, logic [31:0] v);
        t_in_word w;
        w.cmd   = cmd;
        w.key   = k;
        w.value = v;
        return w;
    endfunction

    function automatic logic [31:0] fresh_key();
        case ($urandom_range(0, 15))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return KEY_NEG1;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] stored_key();
        if (tbl_count == 0) return fresh_key();
        return tbl_keys[$urandom_range(0, tbl_count - 1)];
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_row(logic [2:0] cmd, logic [31:0] k, logic [31:0] v, bit typed,
                           logic [1:0] st, logic [31:0] vout, int cnt, bit at_end,
                           logic [31:0] ckey, logic [31:0] cval);
        t_stim_row row;
        row.w                  = mk_word(cmd, k, v);
        row.typed              = typed;
        row.want.status        = st;
        row.want.value_out     = vout;
        row.want.entry_count   = CNT_W'(cnt);
        row.want.cursor_at_end = at_end;
        row.want.cursor_key    = ckey;
        row.want.cursor_value  = cval;
        dir_rows.push_back(row);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("mismatch at word %0d: %s got %h want %h", results_checked, what, got,
                     want);
        end
    endtask

    task automatic check_result(t_out_word got);
        t_out_word want;
        if (pending_results.size() == 0) begin
            report_mismatch("word with none pending", got.cursor_key, 32'h0);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.value_out !== want.value_out)
            report_mismatch("value_out", got.value_out, want.value_out);
        if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        if (got.cursor_at_end !== want.cursor_at_end)
            report_mismatch("cursor_at_end", 32'(got.cursor_at_end),
                            32'(want.cursor_at_end));
        if (got.cursor_key !== want.cursor_key)
            report_mismatch("cursor_key", got.cursor_key, want.cursor_key);
        if (got.cursor_value !== want.cursor_value)
            report_mismatch("cursor_value", got.cursor_value, want.cursor_value);
        results_checked++;
    endtask

    task automatic send_word(t_in_word w, bit typed, t_out_word want);
        t_out_word predicted;
        calm_window = (words_taken >= 600 && words_taken < 900);
        if (!calm_window && $urandom_range(0, 99) < 22) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        predicted = table_apply(w);
        pending_results.push_back(typed ? want : predicted);
        words_taken++;
    endtask

    task automatic send_rand(logic [2:0] cmd, logic [31:0] k, logic [31:0] v);
        send_word(mk_word(cmd, k, v), 1'b0, '0);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left       = 0;
        hold_taken      = 1'b0;
        results_checked = 0;
        mismatch_count  = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) check_result(o_out_word);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm_window && ($urandom_range(0, 99) < 22);
            end
        end
    end

    initial begin
        int          kind;
        int          n;
        int          pick;
        int          stop_at;
        bit          hold_done;
        bit          pause_done;
        logic [31:0] k;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in_word    <= '0;
        tbl_count    = 0;
        cur_pos      = 0;
        cur_live     = 1'b0;
        words_taken  = 0;
        calm_window  = 1'b0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;

        add_row(CMD_CUR_ADV, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 0, 1'b1, 32'h0, 32'h0);
        add_row(CMD_LOOKUP, KEY_MIN, 32'h0, 1'b1, ST_NOT_FOUND, 32'h0, 0, 1'b1, 32'h0,
                32'h0);
        add_row(CMD_REMOVE, KEY_MAX, 32'h0, 1'b1, ST_NOT_FOUND, 32'h0, 0, 1'b1, 32'h0,
                32'h0);
        add_row(CMD_CUR_RST, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 0, 1'b1, 32'h0, 32'h0);
        add_row(CMD_UNUSED_LO, KEY_NEG1, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 0, 1'b1, 32'h0,
                32'h0);
        add_row(CMD_INSERT, KEY_MIN, 32'h0, 1'b1, ST_OK, 32'h0, 1, 1'b1, 32'h0, 32'h0);
        add_row(CMD_INSERT, KEY_MAX, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 2, 1'b1, 32'h0,
                32'h0);
        add_row(CMD_LOOKUP, KEY_MAX, 32'h0, 1'b1, ST_OK, 32'hFFFF_FFFF, 2, 1'b1, 32'h0,
                32'h0);
        add_row(CMD_INSERT, KEY_NEG1, 32'h3F80_0000, 1'b1, ST_OK, 32'h0, 3, 1'b1, 32'h0,
                32'h0);
        add_row(CMD_CUR_RST, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 3, 1'b0, KEY_MIN, 32'h0);
        add_row(CMD_CUR_ADV, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 3, 1'b0, KEY_MAX,
                32'hFFFF_FFFF);
        add_row(CMD_INSERT, KEY_MAX, 32'h1234_5678, 1'b1, ST_OK, 32'h0, 3, 1'b0, KEY_MAX,
                32'h1234_5678);
        // removal ahead of the cursor, then of the cursor entry itself
        add_row(CMD_REMOVE, KEY_MIN, 32'h0, 1'b1, ST_OK, 32'h0, 2, 1'b0, KEY_MAX,
                32'h1234_5678);
        add_row(CMD_REMOVE, KEY_MAX, 32'h0, 1'b1, ST_OK, 32'h0, 1, 1'b0, KEY_NEG1,
                32'h3F80_0000);
        add_row(CMD_CUR_ADV, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 1, 1'b1, 32'h0, 32'h0);
        add_row(CMD_CUR_ADV, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 1, 1'b1, 32'h0, 32'h0);
        add_row(CMD_UNUSED_HI, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 1, 1'b1, 32'h0, 32'h0);
        add_row(CMD_LOOKUP, 32'h0, 32'h0, 1'b1, ST_NOT_FOUND, 32'h0, 1, 1'b1, 32'h0, 32'h0);
        add_row(CMD_INSERT, 32'h0, 32'hAAAA_AAAA, 1'b1, ST_OK, 32'h0, 2, 1'b1, 32'h0, 32'h0);
        add_row(CMD_CUR_RST, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 2, 1'b0, KEY_NEG1,
                32'h3F80_0000);
        add_row(CMD_REMOVE, KEY_NEG1, 32'h0, 1'b1, ST_OK, 32'h0, 1, 1'b0, 32'h0,
                32'hAAAA_AAAA);
        add_row(CMD_REMOVE, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 0, 1'b1, 32'h0, 32'h0);
        add_row(CMD_INSERT, 32'h5555_5555, 32'h5555_5555, 1'b0, '0, '0, 0, 1'b0, '0, '0);
        add_row(CMD_LOOKUP, 32'h5555_5555, 32'h0, 1'b0, '0, '0, 0, 1'b0, '0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

        stop_at = words_taken + RANDOM_WORDS;
        while (words_taken < stop_at) begin
            if (!hold_done && words_taken >= 300) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && words_taken >= 1000) begin
                i_in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                pause_done = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 1) begin
                n = $urandom_range(1, 20);
                repeat (n) begin
                    k = ($urandom_range(0, 4) == 0) ? stored_key() : fresh_key();
                    send_rand(CMD_INSERT, k, rand_value());
                end
            end else if (kind == 2) begin
                // fill to capacity, then updates and refused inserts
                while (tbl_count < TABLE_DEPTH) send_rand(CMD_INSERT, $urandom(), rand_value());
                repeat ($urandom_range(2, 8)) begin
                    k = $urandom_range(0, 1) ? stored_key() : fresh_key();
                    send_rand(CMD_INSERT, k, rand_value());
                end
            end else if (kind <= 5) begin
                repeat (30) begin
                    pick = $urandom_range(0, 99);
                    k = ($urandom_range(0, 9) < 7) ? stored_key() : fresh_key();
                    if (pick < 25) send_rand(CMD_INSERT, k, rand_value());
                    else if (pick < 50) send_rand(CMD_LOOKUP, k, rand_value());
                    else if (pick < 70) send_rand(CMD_REMOVE, k, rand_value());
                    else if (pick < 78) send_rand(CMD_CUR_RST, $urandom(), rand_value());
                    else if (pick < 95) send_rand(CMD_CUR_ADV, $urandom(), rand_value());
                    else send_rand(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom(),
                                   rand_value());
                end
            end else if (kind <= 7) begin
                send_rand(CMD_CUR_RST, $urandom(), rand_value());
                n = tbl_count + 1;
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 20) begin
                        k = (cur_live && $urandom_range(0, 1)) ? tbl_keys[cur_pos] : stored_key();
                        send_rand(CMD_REMOVE, k, rand_value());
                    end else if (pick < 30) begin
                        send_rand(CMD_INSERT, fresh_key(), rand_value());
                    end else begin
                        send_rand(CMD_CUR_ADV, $urandom(), rand_value());
                    end
                end
            end else if (kind == 8) begin
                while (tbl_count > 0) begin
                    if ($urandom_range(0, 99) < 85)
                        send_rand(CMD_REMOVE, stored_key(), rand_value());
                    else
                        send_rand(CMD_LOOKUP, $urandom(), rand_value());
                end
            end else begin
                repeat (4) begin
                    if ($urandom_range(0, 1))
                        send_rand(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom(),
                                  $urandom());
                    else
                        send_rand(CMD_REMOVE, $urandom(), $urandom());
                end
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ordered_key_value_table verification clean");
        end else begin
            $display("ordered_key_value_table verification failed");
        end
        $finish;
    end

endmodule
